@@ design/timed_setpoint_profile_generator_assert.svh @@
// Assertion macros used by the checker.
`ifndef TIMED_SETPOINT_PROFILE_GENERATOR_ASSERT_SVH
`define TIMED_SETPOINT_PROFILE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define TSPG_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSPG_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tspg_pkg.sv @@
`default_nettype none
package tspg_pkg;

  localparam int CORDIC_STEPS = 24;

  localparam logic [34:0]        TWO_PI_Q32  = 35'd26986075409;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [33:0] CORDIC_X0   = 34'sh026DD3B6A;

  // floor(2^66 / TWO_PI_Q32): angle quotient estimate from angle bits 56:34
  localparam logic [31:0] RECIP_2PI_Q66 = 32'd2734261102;

  localparam logic [31:0] EIGHT_S  = 32'd524288;
  localparam logic [31:0] THIRTY_S = 32'd1966080;
  localparam logic [31:0] SIXTY_S  = 32'd3932160;

  localparam logic signed [31:0] SINE1_OFFSET = 32'sd0;
  localparam logic [18:0]        SINE1_PHASE  = 19'd0;
  localparam logic signed [31:0] RAMP_SLOPE   = 32'sd65536;
  localparam logic signed [31:0] SINE2_BIAS   = 32'sd328;
  localparam logic [18:0]        SINE2_PHASE  = 19'd0;

  // period remainder unit: shift of the divisor at start
  localparam logic [4:0] PERIOD_SHIFT = 5'd10;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_SPRINT    = 3'd1;
  localparam logic [2:0] REG_ACCEL     = 3'd2;
  localparam logic [2:0] REG_DECEL     = 3'd3;
  localparam logic [2:0] REG_S1_AMP    = 3'd4;
  localparam logic [2:0] REG_S1_RATE   = 3'd5;
  localparam logic [2:0] REG_S2_AMP    = 3'd6;
  localparam logic [2:0] REG_S2_RATE   = 3'd7;

  typedef enum logic [2:0] {
    SEL_ACCEL,
    SEL_DECEL,
    SEL_RAMP,
    SEL_SINE1,
    SEL_SINE2
  } sel_t;

  typedef struct packed {
    logic        done;
    logic [56:0] rem;
  } mod_status_t;

  function automatic logic [29:0] atan_at(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'h3243F6A8;
      5'd1:  r = 30'h1DAC6705;
      5'd2:  r = 30'h0FADBAFC;
      5'd3:  r = 30'h07F56EA6;
      5'd4:  r = 30'h03FEAB76;
      5'd5:  r = 30'h01FFD55B;
      5'd6:  r = 30'h00FFFAAA;
      5'd7:  r = 30'h007FFF55;
      5'd8:  r = 30'h003FFFEA;
      5'd9:  r = 30'h001FFFFD;
      5'd10: r = 30'h000FFFFF;
      5'd11: r = 30'h0007FFFF;
      5'd12: r = 30'h0003FFFF;
      5'd13: r = 30'h0001FFFF;
      5'd14: r = 30'h0000FFFF;
      5'd15: r = 30'h00007FFF;
      5'd16: r = 30'h00003FFF;
      5'd17: r = 30'h00001FFF;
      5'd18: r = 30'h00000FFF;
      5'd19: r = 30'h000007FF;
      5'd20: r = 30'h000003FF;
      5'd21: r = 30'h000001FF;
      5'd22: r = 30'h000000FF;
      5'd23: r = 30'h0000007F;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -67'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/tspg_divmod.sv @@
`default_nettype none
module tspg_divmod (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [56:0]        dividend,
  input  wire logic [35:0]        divisor,
  input  wire logic [4:0]         shift,
  output tspg_pkg::mod_status_t   status
);
  import tspg_pkg::*;

  logic [59:0] rem;
  logic [59:0] div_sh;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= {3'b0, dividend};
      div_sh <= {24'b0, divisor} << shift;
      cnt    <= shift;
    end else if (busy) begin
      if (rem >= div_sh) rem <= rem - div_sh;
      div_sh <= div_sh >> 1;
      cnt    <= cnt - 5'd1;
    end
  end

  assign status.done = done;
  assign status.rem  = rem[56:0];

endmodule
`default_nettype wire

@@ design/tspg_cordic.sv @@
`default_nettype none
module tspg_cordic (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] z0,
  output logic                    done,
  output logic signed [33:0]      y
);
  import tspg_pkg::*;

  logic signed [33:0] x;
  logic signed [32:0] z;
  logic [4:0]         i;
  logic               busy;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] at;

  assign dx = y >>> i;
  assign dy = x >>> i;
  assign at = $signed({3'b0, atan_at(i)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == 5'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_X0;
      y <= '0;
      z <= {z0[31], z0};
      i <= '0;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
      i <= i + 5'd1;
    end
  end

endmodule
`default_nettype wire

@@ design/timed_setpoint_profile_generator.sv @@
// Takes one tick (step_size) at a time and returns one signed Q16.16 setpoint
// from the elapsed time before the tick. in_stall is high while a tick is
// being worked on and while its result waits to enter the output register.
// Level outputs need only the decision; the ramp adds a multiply and a
// scaling step, and a sine output adds the angle multiply, the angle
// reduction modulo 2*pi (a reciprocal multiply, a back multiply and at most
// one compare and subtract), the 24-iteration CORDIC and the amplitude
// scaling; the periodic schedule first takes the 11-step serial remainder of
// time by the period. One shared multiplier serves the angle, its reduction,
// the amplitude scaling and the ramp.
`default_nettype none
module timed_setpoint_profile_generator (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        step_size,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      setpoint,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);
  import tspg_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_PMOD   = 10'b0000000010,
    ST_DECIDE = 10'b0000000100,
    ST_MUL    = 10'b0000001000,
    ST_ASTART = 10'b0000010000,
    ST_AMOD   = 10'b0000100000,
    ST_CORDIC = 10'b0001000000,
    ST_SCALE  = 10'b0010000000,
    ST_QEST   = 10'b0100000000,
    ST_RED    = 10'b1000000000
  } state_t;

  state_t state;
  state_t after_mul;
  logic   done_pend;

  logic [1:0]         schedule_mode;
  logic [29:0]        sprint_time;
  logic signed [31:0] accel_level;
  logic signed [31:0] decel_level;
  logic signed [31:0] sine1_amplitude;
  logic [23:0]        sine1_rate;
  logic signed [31:0] sine2_amplitude;
  logic [23:0]        sine2_rate;

  logic [31:0]        elapsed_time;
  logic [31:0]        t;
  sel_t               sel;
  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] prod;
  logic signed [31:0] res;

  logic               in_acc;
  logic [32:0]        t_sum;
  logic [32:0]        period;
  logic [31:0]        m;
  logic [56:0]        ang;
  logic [56:0]        ang_q;
  logic [22:0]        q_q;
  logic [57:0]        red_diff;
  logic [35:0]        ang_r;
  logic               red_ok;
  logic signed [34:0] a0;
  logic signed [34:0] a1;
  logic signed [34:0] a2;
  logic signed [66:0] rnd;
  logic signed [31:0] bias;

  logic               mod_start;
  logic [56:0]        mod_dvd;
  logic [35:0]        mod_dsr;
  logic [4:0]         mod_sh;
  mod_status_t        mod_st;
  logic               cor_start;
  logic               cor_done;
  logic signed [33:0] cor_y;

  assign in_stall = (state != ST_IDLE) || done_pend;
  assign in_acc   = in_valid && !in_stall;
  assign t_sum    = {1'b0, elapsed_time} + {17'b0, step_size};
  assign period   = {1'b0, SIXTY_S} + {2'b0, sprint_time, 1'b0};
  assign m        = mod_st.rem[31:0];
  assign ang      = prod[56:0]
                  + {22'b0, (sel == SEL_SINE1) ? SINE1_PHASE : SINE2_PHASE, 16'b0};

  // angle minus quotient estimate times 2*pi (Q32 2*pi = 4 * Q30 2*pi + 1)
  assign red_diff = {1'b0, ang_q} - {prod[55:0], 2'b00} - {35'b0, q_q};
  assign red_ok   = ang_r < {1'b0, TWO_PI_Q32};

  // fold the Q30 angle into [-pi/2, pi/2]
  always_comb begin
    a0 = $signed({2'b0, ang_r[34:2]});
    a1 = (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
    if (a1 > HALF_PI_Q30) a2 = PI_Q30 - a1;
    else if (a1 < -HALF_PI_Q30) a2 = -PI_Q30 - a1;
    else a2 = a1;
  end

  assign mod_start = (state == ST_IDLE) && in_acc && schedule_mode[1];
  assign mod_dvd   = {25'b0, elapsed_time};
  assign mod_dsr   = {3'b0, period};
  assign mod_sh    = PERIOD_SHIFT;

  assign cor_start = (state == ST_AMOD) && red_ok;

  assign bias = (sel == SEL_SINE1) ? SINE1_OFFSET : SINE2_BIAS;
  assign rnd  = ((prod + (67'sd1 <<< 29)) >>> 30) + $signed({{35{bias[31]}}, bias});

  tspg_divmod u_divmod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_dsr),
    .shift    (mod_sh),
    .status   (mod_st)
  );

  tspg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .z0    (a2[31:0]),
    .done  (cor_done),
    .y     (cor_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_mode   <= 2'd0;
      sprint_time     <= 30'd327680;
      accel_level     <= 32'sd65536;
      decel_level     <= -32'sd65536;
      sine1_amplitude <= 32'sd65536;
      sine1_rate      <= 24'd65536;
      sine2_amplitude <= 32'sd1966;
      sine2_rate      <= 24'd98304;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    schedule_mode   <= cfg_data[1:0];
        REG_SPRINT:  sprint_time     <= cfg_data[29:0];
        REG_ACCEL:   accel_level     <= cfg_data;
        REG_DECEL:   decel_level     <= cfg_data;
        REG_S1_AMP:  sine1_amplitude <= cfg_data;
        REG_S1_RATE: sine1_rate      <= cfg_data[23:0];
        REG_S2_AMP:  sine2_amplitude <= cfg_data;
        REG_S2_RATE: sine2_rate      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      after_mul    <= ST_IDLE;
      done_pend    <= 1'b0;
      out_valid    <= 1'b0;
      elapsed_time <= '0;
    end else begin
      if (done_pend && (!out_valid || !out_stall)) begin
        done_pend <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            elapsed_time <= t_sum[32] ? 32'hFFFFFFFF : t_sum[31:0];
            state <= schedule_mode[1] ? ST_PMOD : ST_DECIDE;
          end
        end
        ST_PMOD: begin
          if (mod_st.done) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          priority if (!schedule_mode[1] && !schedule_mode[0]) begin
            if (t < {2'b0, sprint_time}) begin
              done_pend <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              after_mul <= ST_ASTART;
              state     <= ST_MUL;
            end
          end else if (!schedule_mode[1]) begin
            after_mul <= (t > EIGHT_S) ? ST_ASTART : ST_SCALE;
            state     <= ST_MUL;
          end else begin
            if (m < {2'b0, sprint_time} ||
                ({1'b0, m} >= {1'b0, THIRTY_S} &&
                 {1'b0, m} < {1'b0, THIRTY_S} + {3'b0, sprint_time})) begin
              done_pend <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              after_mul <= ST_ASTART;
              state     <= ST_MUL;
            end
          end
        end
        ST_MUL:    state <= after_mul;
        ST_ASTART: begin
          after_mul <= ST_QEST;
          state     <= ST_MUL;
        end
        ST_QEST: begin
          after_mul <= ST_RED;
          state     <= ST_MUL;
        end
        ST_RED:    state <= ST_AMOD;
        ST_AMOD: begin
          if (red_ok) state <= ST_CORDIC;
        end
        ST_CORDIC: begin
          if (cor_done) begin
            after_mul <= ST_SCALE;
            state     <= ST_MUL;
          end
        end
        ST_SCALE: begin
          done_pend <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (state == ST_IDLE && in_acc) t <= elapsed_time;
    if (done_pend && (!out_valid || !out_stall)) setpoint <= res;
    unique case (state)
      ST_DECIDE: begin
        priority if (!schedule_mode[1] && !schedule_mode[0]) begin
          sel   <= SEL_SINE1;
          res   <= accel_level;
          mul_a <= $signed({9'b0, sine1_rate});
        end else if (!schedule_mode[1]) begin
          sel   <= (t > EIGHT_S) ? SEL_SINE2 : SEL_RAMP;
          mul_a <= (t > EIGHT_S) ? $signed({9'b0, sine2_rate})
                                 : {RAMP_SLOPE[31], RAMP_SLOPE};
        end else begin
          sel   <= SEL_SINE2;
          res   <= (m < {2'b0, sprint_time}) ? accel_level : decel_level;
          mul_a <= $signed({9'b0, sine2_rate});
        end
        mul_b <= $signed({2'b0, t});
      end
      ST_ASTART: begin
        ang_q <= ang;
        mul_a <= $signed({1'b0, RECIP_2PI_Q66});
        mul_b <= $signed({11'b0, ang[56:34]});
      end
      ST_QEST: begin
        q_q   <= prod[54:32];
        mul_a <= $signed({10'b0, prod[54:32]});
        mul_b <= $signed({1'b0, TWO_PI_Q30[32:0]});
      end
      ST_RED: begin
        ang_r <= red_diff[35:0];
      end
      ST_AMOD: begin
        if (!red_ok) ang_r <= ang_r - {1'b0, TWO_PI_Q32};
      end
      ST_CORDIC: begin
        mul_a <= (sel == SEL_SINE1) ? {sine1_amplitude[31], sine1_amplitude}
                                    : {sine2_amplitude[31], sine2_amplitude};
        mul_b <= cor_y;
      end
      ST_SCALE: begin
        res <= (sel == SEL_RAMP) ? sat32(prod >>> 16) : sat32(rnd);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ design/tspg_checker.sv @@
`default_nettype none
`include "timed_setpoint_profile_generator_assert.svh"
module tspg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] setpoint
);
  `TSPG_ASSERT_NXT(a_busy_after_item, clk, rst, in_valid && !in_stall, in_stall, "not busy after item")
  `TSPG_ASSERT_NXT(a_reset_no_out, clk, 1'b0, rst, !out_valid, "result after reset")
  `TSPG_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(setpoint), "stalled result changed")
endmodule

bind timed_setpoint_profile_generator tspg_checker u_tspg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .setpoint  (setpoint)
);
`default_nettype wire
